FILE: sv/mlfw_pkg.sv
// ----------------------------------------------------------------------------
// mlfw_pkg
// shared types and constants of the memory lcd frame writer
// ----------------------------------------------------------------------------
package mlfw_pkg;

    localparam int PANEL_ROWS    = 176;
    localparam int BYTES_PER_ROW = 88;
    localparam int PIXEL_COLS    = 2 * BYTES_PER_ROW;
    localparam int STORE_BYTES   = (PANEL_ROWS + 1) * BYTES_PER_ROW;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int COL_W         = $clog2(BYTES_PER_ROW + 1);
    localparam int ROW_W         = 8;

    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(BYTES_PER_ROW);
    localparam logic [7:0]        LINE_CMD   = 8'h90;

    typedef enum logic [1:0] {
        CMD_SET_PIXEL = 2'd0,
        CMD_FILL      = 2'd1,
        CMD_REFRESH   = 2'd2,
        CMD_TICK      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_BUSY = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [7:0]  x_end;
        logic [7:0]  y_end;
        logic [23:0] color;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] spi_byte;
        logic       byte_valid;
        logic       transfer_last;
        logic       select_active;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

endpackage

FILE: sv/mlfw_ifs.sv
// ----------------------------------------------------------------------------
// mlfw stream interfaces
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface mlfw_in_if;
    logic               valid;
    logic               ready;
    mlfw_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mlfw_out_if;
    logic                valid;
    logic                ready;
    mlfw_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/mlfw_frame_mem.sv
// ----------------------------------------------------------------------------
// mlfw_frame_mem
// single-port frame store, two pixels per byte, registered read data
// ----------------------------------------------------------------------------
module mlfw_frame_mem (
    input  logic               i_clk,
    input  mlfw_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);

    logic [7:0] r_mem [mlfw_pkg::STORE_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end

endmodule

FILE: sv/memory_lcd_frame_writer.sv
// ----------------------------------------------------------------------------
// memory_lcd_frame_writer
// 3-bit colour framebuffer and spi line-update byte source for a memory lcd
// ----------------------------------------------------------------------------
// After reset the frame store, rows 0..PANEL_ROWS times BYTES_PER_ROW bytes,
// is cleared one byte per cycle, with no command taken meanwhile.
// One command is worked at a time; a new one is taken once the result of the
// previous one has gone into the output register. A tick of the header, row
// number or trailer sends its byte with no store access, a tick of a data
// byte after one frame store read. A set pixel touches one byte, a fill B * R
// bytes, B the byte columns and R the rows of the rectangle: every touched
// byte is a read and a merged write on the single store port, addressed
// through one shared adder; refresh, busy and rejected commands write none.
// ----------------------------------------------------------------------------
module memory_lcd_frame_writer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mlfw_in_if.sink           i_item,
    mlfw_out_if.source        o_result
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FRD,
        S_FWR,
        S_TRD,
        S_TDAT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_HEAD  = 2'd0,
        PH_ROW   = 2'd1,
        PH_DATA  = 2'd2,
        PH_TRAIL = 2'd3
    } t_phase;

    localparam int ADDR_W = mlfw_pkg::ADDR_W;
    localparam int COL_W  = mlfw_pkg::COL_W;
    localparam int ROW_W  = mlfw_pkg::ROW_W;

    t_state              r_state;
    t_phase              r_phase;
    logic                r_pending;
    logic [ROW_W-1:0]    r_send_row;
    logic [ROW_W-1:0]    r_last_row;
    logic [COL_W-1:0]    r_byte_pos;
    logic [ADDR_W-1:0]   r_tx_base;

    logic [ADDR_W-1:0]   r_base;
    logic [ADDR_W-1:0]   r_waddr;
    logic [COL_W-1:0]    r_col;
    logic [7:0]          r_xs;
    logic [7:0]          r_xe;
    logic [ROW_W-1:0]    r_y;
    logic [ROW_W-1:0]    r_y_end;
    logic [3:0]          r_nib;
    logic                r_arm;

    mlfw_pkg::t_out_item r_res;
    mlfw_pkg::t_out_item r_out;
    logic                r_out_valid;

    mlfw_pkg::t_mem_req  mem_req;
    logic [7:0]          mem_rdata;

    logic [ADDR_W-1:0]   add_a;
    logic [ADDR_W-1:0]   add_b;
    logic [ADDR_W-1:0]   add_sum;

    mlfw_pkg::t_in_item  in_d;
    logic [ROW_W-1:0]    ys_clamp;
    logic [ROW_W-1:0]    ye_clamp;
    logic [ADDR_W-1:0]   row_base;
    logic                pix_bad;
    logic                rect_bad;
    logic [COL_W-1:0]    xs_col;
    logic [COL_W-1:0]    xe_col;
    logic                even_ok;
    logic                odd_ok;
    logic [7:0]          merged;
    logic [COL_W:0]      pos_next;

    assign in_d     = i_item.data;
    assign ys_clamp = (in_d.y_start == '0) ? ROW_W'(1) : in_d.y_start;
    assign ye_clamp = (in_d.y_end == '0) ? ROW_W'(1) : in_d.y_end;
    assign row_base = ADDR_W'(ADDR_W'(ys_clamp) * mlfw_pkg::ROW_STRIDE);
    assign pix_bad  = (int'(in_d.x_start) >= mlfw_pkg::PIXEL_COLS)
                   || (int'(ys_clamp) > mlfw_pkg::PANEL_ROWS);
    assign rect_bad = (in_d.x_start > in_d.x_end) || (in_d.y_start > in_d.y_end)
                   || (int'(in_d.x_end) >= mlfw_pkg::PIXEL_COLS)
                   || (int'(in_d.y_end) > mlfw_pkg::PANEL_ROWS);

    assign xs_col   = COL_W'(r_xs >> 1);
    assign xe_col   = COL_W'(r_xe >> 1);
    assign even_ok  = (r_col != xs_col) || !r_xs[0];
    assign odd_ok   = (r_col != xe_col) || r_xe[0];
    assign merged   = {even_ok ? r_nib : mem_rdata[7:4], odd_ok ? r_nib : mem_rdata[3:0]};
    assign pos_next = {1'b0, r_byte_pos} + (COL_W + 1)'(1);

    // shared address adder
    always_comb begin
        add_a = r_base;
        add_b = '0;
        case (r_state)
            S_CLEAR: add_b = ADDR_W'(1);
            S_FRD:   add_b = ADDR_W'(r_col);
            S_FWR:   add_b = mlfw_pkg::ROW_STRIDE;
            S_TRD: begin
                add_a = r_tx_base;
                add_b = ADDR_W'(r_byte_pos);
            end
            S_TDAT: begin
                add_a = r_tx_base;
                add_b = mlfw_pkg::ROW_STRIDE;
            end
            default: add_b = '0;
        endcase
    end

    assign add_sum = add_a + add_b;

    always_comb begin
        mem_req.we    = 1'b0;
        mem_req.addr  = add_sum;
        mem_req.wdata = merged;
        case (r_state)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = r_base;
                mem_req.wdata = '0;
            end
            S_FWR: begin
                mem_req.we   = 1'b1;
                mem_req.addr = r_waddr;
            end
            default: mem_req.we = 1'b0;
        endcase
    end

    mlfw_frame_mem u_frame_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign i_item.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_HEAD;
            r_pending   <= 1'b0;
            r_send_row  <= '0;
            r_last_row  <= '0;
            r_byte_pos  <= '0;
            r_tx_base   <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (int'(r_base) == mlfw_pkg::STORE_BYTES - 1) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_base <= add_sum;
                    end
                end
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_res.status        <= mlfw_pkg::ST_OK;
                        r_res.spi_byte      <= '0;
                        r_res.byte_valid    <= 1'b0;
                        r_res.transfer_last <= 1'b0;
                        r_res.select_active <= r_pending;
                        r_state             <= S_DONE;
                        r_nib  <= {in_d.color[23], in_d.color[15], in_d.color[7], 1'b0};
                        r_xs   <= in_d.x_start;
                        r_col  <= COL_W'(in_d.x_start >> 1);
                        r_y    <= ys_clamp;
                        r_base <= row_base;
                        if (in_d.cmd != mlfw_pkg::CMD_TICK && r_pending) begin
                            r_res.status <= mlfw_pkg::ST_BUSY;
                        end else begin
                            case (mlfw_pkg::t_cmd'(in_d.cmd))
                                mlfw_pkg::CMD_SET_PIXEL: begin
                                    if (pix_bad) begin
                                        r_res.status <= mlfw_pkg::ST_BAD;
                                    end else begin
                                        r_xe    <= in_d.x_start;
                                        r_y_end <= ys_clamp;
                                        r_arm   <= 1'b0;
                                        r_state <= S_FRD;
                                    end
                                end
                                mlfw_pkg::CMD_FILL: begin
                                    if (rect_bad) begin
                                        r_res.status <= mlfw_pkg::ST_BAD;
                                    end else begin
                                        r_xe       <= in_d.x_end;
                                        r_y_end    <= ye_clamp;
                                        r_arm      <= 1'b1;
                                        r_send_row <= ys_clamp;
                                        r_last_row <= ye_clamp;
                                        r_tx_base  <= row_base;
                                        r_byte_pos <= '0;
                                        r_phase    <= PH_HEAD;
                                        r_state    <= S_FRD;
                                    end
                                end
                                mlfw_pkg::CMD_REFRESH: begin
                                    r_send_row <= ROW_W'(1);
                                    r_last_row <= ROW_W'(mlfw_pkg::PANEL_ROWS);
                                    r_tx_base  <= mlfw_pkg::ROW_STRIDE;
                                    r_byte_pos <= '0;
                                    r_phase    <= PH_HEAD;
                                    r_pending  <= 1'b1;
                                end
                                default: begin
                                    if (r_pending) begin
                                        r_res.byte_valid <= 1'b1;
                                        case (r_phase)
                                            PH_HEAD: begin
                                                r_res.spi_byte <= mlfw_pkg::LINE_CMD;
                                                r_phase        <= PH_ROW;
                                            end
                                            PH_ROW: begin
                                                r_res.spi_byte <= r_send_row;
                                                r_byte_pos     <= '0;
                                                r_phase        <= PH_DATA;
                                            end
                                            PH_DATA: begin
                                                r_state <= S_TRD;
                                            end
                                            default: begin
                                                if (r_byte_pos == '0) begin
                                                    r_byte_pos <= COL_W'(1);
                                                end else begin
                                                    r_res.transfer_last <= 1'b1;
                                                    r_byte_pos          <= '0;
                                                    r_phase             <= PH_HEAD;
                                                    r_pending           <= 1'b0;
                                                end
                                            end
                                        endcase
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_FRD: begin
                    r_waddr <= add_sum;
                    r_state <= S_FWR;
                end
                S_FWR: begin
                    r_state <= S_FRD;
                    if (r_col == xe_col) begin
                        if (r_y == r_y_end) begin
                            r_pending <= r_arm;
                            r_state   <= S_DONE;
                        end else begin
                            r_y    <= r_y + ROW_W'(1);
                            r_base <= add_sum;
                            r_col  <= xs_col;
                        end
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
                S_TRD: begin
                    r_state <= S_TDAT;
                end
                S_TDAT: begin
                    r_res.spi_byte <= mem_rdata;
                    r_state        <= S_DONE;
                    if (pos_next >= (COL_W + 1)'(mlfw_pkg::BYTES_PER_ROW)) begin
                        r_byte_pos <= '0;
                        if (r_send_row >= r_last_row) begin
                            r_phase <= PH_TRAIL;
                        end else begin
                            r_send_row <= r_send_row + ROW_W'(1);
                            r_tx_base  <= add_sum;
                            r_phase    <= PH_HEAD;
                        end
                    end else begin
                        r_byte_pos <= pos_next[COL_W-1:0];
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_last_in_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.data.transfer_last
        |-> o_result.data.byte_valid && o_result.data.select_active)
        else $error("last byte outside a transfer");

    a_busy_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.data.status == mlfw_pkg::ST_BUSY
        |-> !o_result.data.byte_valid && o_result.data.select_active)
        else $error("busy result carries a byte");

    a_pos_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending && r_phase == PH_DATA
        |-> r_byte_pos < COL_W'(mlfw_pkg::BYTES_PER_ROW))
        else $error("byte position past row end");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_send_row <= r_last_row)
        else $error("send row past last row");

    a_write_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> int'(mem_req.addr) < mlfw_pkg::STORE_BYTES)
        else $error("frame store write out of range");

endmodule
